[rtl/core/hsvrgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB package
// Beat types, fixed-point constants and sector codes shared by the converter
// and its channel scaler.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // One request beat: hue in 1/64 degree, saturation and value as 8-bit fractions.
   typedef struct packed {
      logic [14:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } hsv_req_type;

   // One response beat: three color channels and a constant alpha.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgb_rsp_type;

   // Hue circle split into six sectors of 60 degrees.
   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   // Hue geometry in 1/64 degree units.
   localparam logic [14:0] HUE_SECTOR = 15'd3840;
   localparam logic [14:0] HUE_FULL   = 15'd23040;

   // Width of a distance from the sector edge, 0 to 3840.
   localparam int DIST_W = 12;
   localparam logic [DIST_W-1:0] DIST_FULL = 12'd3840;

   // Scale denominator 255 * 3840 and half of it for rounding.
   localparam int PROD_W = 20;
   localparam int NUM_W  = 28;
   localparam logic [PROD_W-1:0] SCALE_DEN = 20'd979200;
   localparam logic [NUM_W-1:0]  HALF_DEN  = 28'd489600;

   // Division by 979200 = 256 * 3825: drop 8 bits, then multiply by
   // ceil(2^32 / 3825). Exact for every 20-bit dividend.
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 32;
   localparam int DIV_DROP    = 8;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 21'd1122868;

   localparam logic [7:0] CHAN_MAX   = 8'd255;
   localparam logic [7:0] ALPHA_FULL = 8'd255;

endpackage

[rtl/core/hsvrgb_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB channel scaler
// Three-stage pipeline computing round(v * (979200 - s * d) / 979200),
// saturated at 255, where d is the hue distance term of the channel.
// ----------------------------------------------------------------------------
module hsvrgb_chan (
   input  logic                          clock,
   input  logic [7:0]                    sat,
   input  logic [7:0]                    val,
   input  logic [hsvrgb_pkg::DIST_W-1:0] hue_delta,
   output logic [7:0]                    level
);
   import hsvrgb_pkg::*;

   localparam int QUOT_W = NUM_W - DIV_DROP + RECIP_W - RECIP_SHIFT;

   logic [PROD_W-1:0]            sd_prod_ff;
   logic [7:0]                   val_a_ff;
   logic [NUM_W-1:0]             num_ff;
   logic [PROD_W-1:0]            scale_in;
   logic [NUM_W-1:0]             num_in;
   logic [NUM_W-1:0]             biased;
   logic [NUM_W-DIV_DROP-1:0]    dividend;
   logic [NUM_W-DIV_DROP+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]            quot;
   logic [7:0]                   level_in;
   logic [7:0]                   level_ff;

   // Stage A: saturation times distance.
   always_ff @(posedge clock) begin
      sd_prod_ff <= PROD_W'(sat) * PROD_W'(hue_delta);
      val_a_ff   <= val;
   end

   // Stage B: scale factor and product with the value.
   always_comb begin
      scale_in = SCALE_DEN - sd_prod_ff;
      num_in   = NUM_W'(val_a_ff) * NUM_W'(scale_in);
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   // Stage C: round, divide by reciprocal multiplication and saturate.
   always_comb begin
      biased     = num_ff + HALF_DEN;
      dividend   = biased[NUM_W-1:DIV_DROP];
      recip_prod = (NUM_W-DIV_DROP+RECIP_W)'(dividend)
                   * (NUM_W-DIV_DROP+RECIP_W)'(RECIP_MULT);
      quot       = recip_prod[NUM_W-DIV_DROP+RECIP_W-1:RECIP_SHIFT];
      if (quot > QUOT_W'(CHAN_MAX)) begin
         level_in = CHAN_MAX;
      end else begin
         level_in = quot[7:0];
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

[rtl/core/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a hue, saturation, value beat into red, green, blue and alpha.
// ----------------------------------------------------------------------------
// The converter takes one beat in every clock cycle and busy stays low, so
// start may be held high for a continuous stream. Each result appears on
// rsp_data with rsp_valid high for one cycle, in request order, once its
// request has passed the five register stages: the sector decode stage, the
// three stages of the channel scaler (distance product, value product,
// reciprocal division) and the output routing register. The receiver cannot
// hold results off and the pipeline never stalls.
module hsv_to_rgb_converter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  hsvrgb_pkg::hsv_req_type  req_data,
   output logic                     rsp_valid,
   output hsvrgb_pkg::rgb_rsp_type  rsp_data
);
   import hsvrgb_pkg::*;

   localparam int CHAN_LAT = 3;

   logic                 accept;
   logic [14:0]          hue_wrap;
   logic [14:0]          sector_base;
   sector_type           sector_in;
   logic [DIST_W-1:0]    rem_in;

   sector_type           sector_ff;
   logic [DIST_W-1:0]    rem_ff;
   logic [7:0]           sat_ff;
   logic [7:0]           val_ff;
   logic                 s1_valid_ff;

   logic                 odd_sector;
   logic [DIST_W-1:0]    sec_dist;
   logic [7:0]           sec_level;
   logic [7:0]           zero_level;

   sector_type           sector_pipe_ff [CHAN_LAT];
   logic [7:0]           val_pipe_ff    [CHAN_LAT];
   logic [CHAN_LAT-1:0]  valid_pipe_ff;

   rgb_rsp_type          rsp_in;
   rgb_rsp_type          rsp_data_ff;
   logic                 rsp_valid_ff;

   assign accept = start & ~busy;
   assign busy   = 1'b0;

   // Sector decode: wrap the hue once and find its sector and offset.
   always_comb begin
      hue_wrap = req_data.hue;
      if (req_data.hue >= HUE_FULL) begin
         hue_wrap = req_data.hue - HUE_FULL;
      end
      if (hue_wrap < HUE_SECTOR) begin
         sector_in   = SEC_R_TO_Y;
         sector_base = 15'd0;
      end else if (hue_wrap < 15'(HUE_SECTOR * 2)) begin
         sector_in   = SEC_Y_TO_G;
         sector_base = HUE_SECTOR;
      end else if (hue_wrap < 15'(HUE_SECTOR * 3)) begin
         sector_in   = SEC_G_TO_C;
         sector_base = 15'(HUE_SECTOR * 2);
      end else if (hue_wrap < 15'(HUE_SECTOR * 4)) begin
         sector_in   = SEC_C_TO_B;
         sector_base = 15'(HUE_SECTOR * 3);
      end else if (hue_wrap < 15'(HUE_SECTOR * 5)) begin
         sector_in   = SEC_B_TO_M;
         sector_base = 15'(HUE_SECTOR * 4);
      end else begin
         sector_in   = SEC_M_TO_R;
         sector_base = 15'(HUE_SECTOR * 5);
      end
      rem_in = DIST_W'(hue_wrap - sector_base);
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      rem_ff    <= rem_in;
      sat_ff    <= req_data.saturation;
      val_ff    <= req_data.brightness;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // The secondary channel rises in even sectors and falls in odd ones;
   // its distance from full weight is 3840 - w.
   always_comb begin
      odd_sector = (sector_ff == SEC_Y_TO_G) || (sector_ff == SEC_C_TO_B) ||
                   (sector_ff == SEC_M_TO_R);
      if (odd_sector) begin
         sec_dist = rem_ff;
      end else begin
         sec_dist = DIST_FULL - rem_ff;
      end
   end

   hsvrgb_chan u_sec_chan (
      .clock     (clock),
      .sat       (sat_ff),
      .val       (val_ff),
      .hue_delta (sec_dist),
      .level     (sec_level)
   );

   hsvrgb_chan u_zero_chan (
      .clock     (clock),
      .sat       (sat_ff),
      .val       (val_ff),
      .hue_delta (DIST_FULL),
      .level     (zero_level)
   );

   // Sector, value and valid travel alongside the channel scalers.
   always_ff @(posedge clock) begin
      sector_pipe_ff[0] <= sector_ff;
      val_pipe_ff[0]    <= val_ff;
      for (int i = 1; i < CHAN_LAT; i++) begin
         sector_pipe_ff[i] <= sector_pipe_ff[i-1];
         val_pipe_ff[i]    <= val_pipe_ff[i-1];
      end
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[CHAN_LAT-2:0], s1_valid_ff};
      end
   end

   // Output routing: chroma equals the value, the others come from the scalers.
   always_comb begin
      rsp_in.alpha = ALPHA_FULL;
      unique case (sector_pipe_ff[CHAN_LAT-1])
         SEC_R_TO_Y: begin
            rsp_in.red   = val_pipe_ff[CHAN_LAT-1];
            rsp_in.green = sec_level;
            rsp_in.blue  = zero_level;
         end
         SEC_Y_TO_G: begin
            rsp_in.red   = sec_level;
            rsp_in.green = val_pipe_ff[CHAN_LAT-1];
            rsp_in.blue  = zero_level;
         end
         SEC_G_TO_C: begin
            rsp_in.red   = zero_level;
            rsp_in.green = val_pipe_ff[CHAN_LAT-1];
            rsp_in.blue  = sec_level;
         end
         SEC_C_TO_B: begin
            rsp_in.red   = zero_level;
            rsp_in.green = sec_level;
            rsp_in.blue  = val_pipe_ff[CHAN_LAT-1];
         end
         SEC_B_TO_M: begin
            rsp_in.red   = sec_level;
            rsp_in.green = zero_level;
            rsp_in.blue  = val_pipe_ff[CHAN_LAT-1];
         end
         default: begin
            rsp_in.red   = val_pipe_ff[CHAN_LAT-1];
            rsp_in.green = zero_level;
            rsp_in.blue  = sec_level;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_pipe_ff[CHAN_LAT-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/hsvrgb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the converter ports for latency and color invariants.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input hsvrgb_pkg::hsv_req_type  req_data,
   input logic                     rsp_valid,
   input hsvrgb_pkg::rgb_rsp_type  rsp_data
);
   import hsvrgb_pkg::*;

   // Every accepted beat yields a response.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted beat produced no response after five cycles");

   // No response appears without a matching earlier request.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("response without a matching request");

   // One of the three channels always equals the requested value.
   a_chroma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red == $past(req_data.brightness, 5)) ||
                    (rsp_data.green == $past(req_data.brightness, 5)) ||
                    (rsp_data.blue == $past(req_data.brightness, 5)))
      else $error("no channel carries the requested value");

   // Zero saturation gives a gray with full alpha.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_data.saturation, 5) == 8'd0)) |->
         (rsp_data.red == rsp_data.green) && (rsp_data.green == rsp_data.blue) &&
         (rsp_data.alpha == ALPHA_FULL))
      else $error("zero saturation did not give a gray response");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
